// ===== hw/rtl/ssc_pkg.sv =====
// shared types, constants and segment decode for the seven-segment counter
`timescale 1ns / 1ps
`default_nettype none
package ssc_pkg;

  localparam int NUM_DIGITS  = 4;
  localparam int DIGIT_IDX_W = 2;
  localparam int LIMIT_W     = 16;
  localparam int DIGIT_EN_W  = 4;
  localparam int SEG_W       = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd50;

  typedef logic [3:0] bcd_t;

  // element 3 is thousands, element 0 is units
  typedef bcd_t [NUM_DIGITS-1:0] bcd_count_t;

  typedef struct packed {
    logic       valid;
    bcd_count_t count;
  } queue_head_t;

  localparam bcd_t BCD_NINE = 4'd9;

  // active-low selects in emission order: thousands, hundreds, tens, units
  localparam logic [DIGIT_EN_W-1:0] DIGIT_ENABLES [NUM_DIGITS] = '{
    4'b1110, 4'b1101, 4'b1011, 4'b0111
  };

  localparam logic [DIGIT_IDX_W-1:0] LAST_IDX = DIGIT_IDX_W'(NUM_DIGITS - 1);

  function automatic logic [SEG_W-1:0] seg_pattern(input bcd_t d);
    logic [SEG_W-1:0] p;
    unique case (d)
      4'd0:    p = 8'b0011_1111;
      4'd1:    p = 8'b0000_0110;
      4'd2:    p = 8'b0101_1011;
      4'd3:    p = 8'b0100_1111;
      4'd4:    p = 8'b0110_0110;
      4'd5:    p = 8'b0110_1101;
      4'd6:    p = 8'b0111_1101;
      4'd7:    p = 8'b0000_0111;
      4'd8:    p = 8'b0111_1111;
      4'd9:    p = 8'b0110_1111;
      default: p = 8'b0000_0000;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ssc_if.sv =====
// request channel interfaces for tick input and digit frame output
`timescale 1ns / 1ps
`default_nettype none
interface ssc_in_if import ssc_pkg::*;;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface ssc_out_if import ssc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [DIGIT_EN_W-1:0] digit_enables;
  logic [SEG_W-1:0]      segments;
  logic                  last_digit;

  modport source (output valid, output digit_enables, output segments, output last_digit,
                  input ready);
  modport sink   (input valid, input digit_enables, input segments, input last_digit,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ssc_front.sv =====
// front end: prescaler, bcd counter and limit register, pushes count snapshots
`timescale 1ns / 1ps
`default_nettype none
module ssc_front import ssc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  ssc_in_if.sink             tick_chan,
  input  logic               wr_en,
  input  logic [LIMIT_W-1:0] wr_data,
  input  logic               queue_full,
  output logic               push,
  output bcd_count_t         push_count
);

  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] prescale;
  logic [LIMIT_W-1:0] prescale_next;
  bcd_count_t         count;
  bcd_count_t         count_next;
  bcd_count_t         count_inc;
  logic [LIMIT_W:0]   prescale_sum;
  logic               hit;
  logic               accept;

  assign tick_chan.ready = !queue_full;
  assign accept          = tick_chan.valid && !queue_full;

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (carry) begin
        if (count[i] == BCD_NINE) begin
          count_inc[i] = '0;
        end else begin
          count_inc[i] = count[i] + 4'd1;
          carry        = 1'b0;
        end
      end else begin
        count_inc[i] = count[i];
      end
    end
  end

  always_comb begin
    prescale_sum  = {1'b0, prescale} + {{LIMIT_W{1'b0}}, 1'b1};
    hit           = prescale_sum >= {1'b0, limit};
    prescale_next = prescale;
    count_next    = count;
    if (accept && tick_chan.tick) begin
      if (hit) begin
        prescale_next = '0;
        count_next    = count_inc;
      end else begin
        prescale_next = prescale_sum[LIMIT_W-1:0];
      end
    end
  end

  assign push       = accept;
  assign push_count = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit    <= LIMIT_RESET;
      prescale <= '0;
      count    <= '0;
    end else begin
      if (wr_en) begin
        limit <= wr_data;
      end
      prescale <= prescale_next;
      count    <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssc_queue.sv =====
// short queue of count snapshots between front and back
`timescale 1ns / 1ps
`default_nettype none
module ssc_queue import ssc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  bcd_count_t  push_count,
  input  logic        pop,
  output logic        full,
  output queue_head_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  bcd_count_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] level;

  assign full       = level == CNT_W'(DEPTH);
  assign head.valid = level != '0;
  assign head.count = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + CNT_W'(1);
      end else if (pop && !push) begin
        level <= level - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssc_back.sv =====
// back end: walks the four digits of the queue head into the output register
`timescale 1ns / 1ps
`default_nettype none
module ssc_back import ssc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  ssc_out_if.source   frame_chan
);

  logic [DIGIT_IDX_W-1:0] idx;
  logic                   load;
  logic                   take;
  bcd_t                   digit;

  assign load  = !frame_chan.valid || frame_chan.ready;
  assign take  = load && head.valid;
  assign pop   = take && (idx == LAST_IDX);
  assign digit = head.count[LAST_IDX - idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_chan.valid <= 1'b0;
      idx              <= '0;
    end else if (take) begin
      frame_chan.valid <= 1'b1;
      idx              <= idx + DIGIT_IDX_W'(1);
    end else if (load) begin
      frame_chan.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_chan.digit_enables <= DIGIT_ENABLES[idx];
      frame_chan.segments      <= seg_pattern(digit);
      frame_chan.last_digit    <= idx == LAST_IDX;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/seven_segment_counter_display_top.sv =====
// four-digit multiplexed seven-segment counter, top level
//
// tick_chan carries one request per refresh period; tick 1 advances the
// prescaler, and when it reaches the limit the decimal count steps, 9999
// wrapping to 0. tick 0 only refreshes. every request yields four frames on
// frame_chan, thousands first, each with the digit's segment byte and a
// one-cold active-low digit select; the units frame has last_digit set.
// wr_en/wr_data write the prescaler limit (ticks per count); the user must
// write it only while idle, which the block itself does not enforce.
// a request's snapshot passes the queue and the back end's output register;
// its frames then follow one per cycle while frame_chan is ready.
// the front takes a request every cycle while the snapshot queue has room,
// so QUEUE_DEPTH requests can be taken while frames are stalled.
// when frame_chan is stalled the output frame holds and the queue fills,
// after which tick_chan.ready drops.
// reset clears count, prescaler and queue and sets the limit to 50.
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_counter_display_top import ssc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  ssc_in_if.sink             tick_chan,
  ssc_out_if.source          frame_chan,
  input  logic               wr_en,
  input  logic [LIMIT_W-1:0] wr_data
);

  logic        push;
  logic        pop;
  logic        queue_full;
  bcd_count_t  push_count;
  queue_head_t head;

  ssc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .tick_chan  (tick_chan),
    .wr_en      (wr_en),
    .wr_data    (wr_data),
    .queue_full (queue_full),
    .push       (push),
    .push_count (push_count)
  );

  ssc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_count (push_count),
    .pop        (pop),
    .full       (queue_full),
    .head       (head)
  );

  ssc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .frame_chan (frame_chan)
  );

  a_one_digit_selected: assert property (@(posedge clk) disable iff (rst)
    frame_chan.valid |-> $onehot(~frame_chan.digit_enables))
    else $error("digit select not one-cold");

  a_last_is_units: assert property (@(posedge clk) disable iff (rst)
    frame_chan.valid && frame_chan.last_digit |->
      frame_chan.digit_enables == DIGIT_ENABLES[NUM_DIGITS-1])
    else $error("last frame not on units digit");

  a_frames_contiguous: assert property (@(posedge clk) disable iff (rst)
    frame_chan.valid && frame_chan.ready && !frame_chan.last_digit |=> frame_chan.valid)
    else $error("gap inside a four-frame group");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> frame_chan.valid && frame_chan.last_digit)
    else $error("snapshot released without units frame");

endmodule
`default_nettype wire

// ===== tb/ssc_frame_checker.sv =====
`timescale 1ns / 1ps
// frame checker: predicts the digit frames of each tick request and compares
module ssc_frame_checker import ssc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [LIMIT_W-1:0] wr_data,
  input  logic               req_valid,
  input  logic               req_ready,
  input  logic               req_tick,
  input  logic               frm_valid,
  input  logic               frm_ready,
  input  logic [DIGIT_EN_W-1:0] frm_enables,
  input  logic [SEG_W-1:0]   frm_segments,
  input  logic               frm_last,
  output int                 mismatches,
  output int                 frames_owed
);

  localparam int unsigned COUNT_TOP = 9999;
  localparam int MAX_LINES = 40;

  localparam logic [SEG_W-1:0] SEG_LUT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic [DIGIT_EN_W-1:0] enables;
    logic [SEG_W-1:0]      segs;
    logic                  last;
  } digit_frame_t;

  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] prescale_q;
  int unsigned        count_q;
  digit_frame_t       frames_due [$];

  initial mismatches = 0;
  initial frames_owed = 0;

  task automatic log_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_LINES)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic take_request(input logic advance);
    logic [LIMIT_W:0] nxt;
    int unsigned      place;
    int               k;
    digit_frame_t     f;
    if (advance) begin
      nxt = {1'b0, prescale_q} + 1'b1;
      if (nxt >= {1'b0, limit_q}) begin
        count_q = (count_q >= COUNT_TOP) ? 0 : count_q + 1;
        prescale_q = '0;
      end else begin
        prescale_q = nxt[LIMIT_W-1:0];
      end
    end
    place = 1000;
    for (k = 0; k < NUM_DIGITS; k++) begin
      f.enables = ~(4'b0001 << k);
      f.segs = SEG_LUT[(count_q / place) % 10];
      f.last = (k == NUM_DIGITS - 1);
      frames_due.push_back(f);
      place = place / 10;
    end
  endtask

  always @(posedge clk) begin
    digit_frame_t want;
    if (rst) begin
      limit_q = LIMIT_RESET;
      prescale_q = '0;
      count_q = 0;
      frames_due.delete();
    end else begin
      if (wr_en) limit_q = wr_data;
      if (req_valid && req_ready) take_request(req_tick);
      if (frm_valid && frm_ready) begin
        if (frames_due.size() == 0) begin
          log_mismatch("unexpected frame", frm_segments, 0);
        end else begin
          want = frames_due.pop_front();
          if (frm_enables !== want.enables)
            log_mismatch("digit_enables", frm_enables, want.enables);
          if (frm_segments !== want.segs)
            log_mismatch("segments", frm_segments, want.segs);
          if (frm_last !== want.last)
            log_mismatch("last_digit", frm_last, want.last);
        end
      end
    end
    frames_owed <= frames_due.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, tick requests, frame sink and verdict
module tb;
  import ssc_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_OFF     = 64;
  localparam int RANDOM_ITEMS = 300;
  localparam int RANDOM_PHASE = 50;
  localparam int TAIL_CYCLES  = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en;
  logic [LIMIT_W-1:0] wr_data;
  bit                 tx_calm = 1'b0;
  int                 mismatches;
  int                 frames_owed;

  ssc_in_if  tick_chan ();
  ssc_out_if frame_chan ();

  seven_segment_counter_display_top uut (
    .clk        (clk),
    .rst        (rst),
    .tick_chan  (tick_chan),
    .frame_chan (frame_chan),
    .wr_en      (wr_en),
    .wr_data    (wr_data)
  );

  ssc_frame_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_data      (wr_data),
    .req_valid    (tick_chan.valid),
    .req_ready    (tick_chan.ready),
    .req_tick     (tick_chan.tick),
    .frm_valid    (frame_chan.valid),
    .frm_ready    (frame_chan.ready),
    .frm_enables  (frame_chan.digit_enables),
    .frm_segments (frame_chan.segments),
    .frm_last     (frame_chan.last_digit),
    .mismatches   (mismatches),
    .frames_owed  (frames_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic offer_tick(input logic t);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      tick_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_chan.valid <= 1'b1;
    tick_chan.tick <= t;
    do @(posedge clk); while (!tick_chan.ready);
  endtask

  task automatic settle();
    tick_chan.valid <= 1'b0;
    do @(posedge clk); while (frames_owed != 0);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    settle();
    wr_en <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  initial begin : watchdog
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : frame_sink
    int  gap;
    int  taken;
    bit  calm;
    taken = 0;
    calm = 1'b0;
    frame_chan.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      if (taken == 180 || taken == 760) gap = HOLD_OFF;
      else if (calm) gap = 0;
      else gap = $urandom_range(0, 11);
      if (gap > 0) begin
        frame_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      frame_chan.ready <= 1'b1;
      do @(posedge clk); while (!frame_chan.valid);
      taken++;
    end
  end

  initial begin : stimulus
    int i;
    tick_chan.valid = 1'b0;
    tick_chan.tick = 1'b0;
    wr_en = 1'b0;
    wr_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // refresh only, then prescaler steps below the reset limit
    offer_tick(1'b0);
    repeat (3) offer_tick(1'b1);
    // zero limit counts on every tick
    set_limit('0);
    repeat (3) offer_tick(1'b1);
    offer_tick(1'b0);
    set_limit('1);
    repeat (4) offer_tick(1'b1);
    // limit lowered below the prescaler
    set_limit(16'd3);
    repeat (2) offer_tick(1'b1);
    set_limit(16'd1);
    repeat (3) offer_tick(1'b1);
    set_limit(16'd2);
    repeat (4) offer_tick(1'b1);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % RANDOM_PHASE == 0) begin
        case ($urandom_range(0, 5))
          0:       set_limit(16'd1);
          1:       set_limit(16'd2);
          2:       set_limit(LIMIT_W'($urandom_range(3, 12)));
          3:       set_limit(LIMIT_W'($urandom_range(13, 40)));
          4:       set_limit('1);
          default: set_limit('0);
        endcase
      end
      offer_tick($urandom_range(0, 3) != 0);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && frames_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_if.sv
hw/rtl/ssc_front.sv
hw/rtl/ssc_queue.sv
hw/rtl/ssc_back.sv
hw/rtl/seven_segment_counter_display_top.sv
tb/ssc_frame_checker.sv
tb/tb.sv
